FILE: rtl/core/ich_pkg.sv
// Shared types and constants for the interval coverage histogram core.
`default_nettype none
package ich_pkg;

  // Histogram geometry
  localparam int MAX_BINS = 1024;
  localparam int BIN_AW   = $clog2(MAX_BINS);
  localparam int LIM_W    = BIN_AW + 1;

  // Divider geometry: dividend is twice a nonnegative 32-bit distance
  localparam int DIV_W  = 33;
  localparam int DIV_CW = $clog2(DIV_W + 1);

  // Operation codes of the input channel
  localparam logic [1:0] OP_ADD  = 2'd0;
  localparam logic [1:0] OP_END  = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_AXIS_LOW    = 2'd0;
  localparam logic [1:0] CFG_BIN_WIDTH   = 2'd1;
  localparam logic [1:0] CFG_BINS_IN_USE = 2'd2;

  // Configuration reset values
  localparam logic [31:0]      AXIS_LOW_RST    = 32'd0;
  localparam logic [31:0]      BIN_WIDTH_RST   = 32'd360448;
  localparam logic [LIM_W-1:0] BINS_IN_USE_RST = LIM_W'(1000);

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_DIV,
    ST_TOG_RD,
    ST_TOG_WR,
    ST_WALK,
    ST_DONE
  } ich_state_t;

endpackage
`default_nettype wire

FILE: rtl/core/interval_coverage_histogram_core.sv
// Top level of the interval coverage histogram: sequencer, memories, registers.
//
// Channel | Direction | Handshake            | Payload
// --------+-----------+----------------------+-----------------------------------------
// in_     | input     | in_valid / in_stall  | operation, point_value, read_index
// out_    | output    | out_valid / out_stall| bin_value, events_seen
// cfg_    | input     | cfg_we               | cfg_index, cfg_wdata
//
// Add point: a 33-step divide followed by a toggle read-modify-write. End of event:
// a walk over max(bins in use - 1, marks touched) bins, one bin per cycle through the
// count memory port. After reset a clearing pass zeroes both memories; no input is taken.
// One item at a time; a finished result waits in the output register under
// out_stall while the next item is already taken and worked on.
`default_nettype none
module interval_coverage_histogram_core (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // input channel
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [1:0]                  in_operation,
  input  wire logic signed [31:0]          in_point_value,
  input  wire logic [9:0]                  in_read_index,
  // result channel
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [31:0]                      out_bin_value,
  output logic [31:0]                      out_events_seen,
  // configuration
  input  wire logic                        cfg_we,
  input  wire logic [1:0]                  cfg_index,
  input  wire logic [31:0]                 cfg_wdata
);
  import ich_pkg::*;

  ich_state_t state_r, state_nxt;

  // Configuration registers
  logic [31:0]       axis_low_r;
  logic [31:0]       bin_width_r;
  logic [LIM_W-1:0]  bins_in_use_r;

  // Item registers
  logic [1:0]        op_r;
  logic [31:0]       pt_r;
  logic [BIN_AW-1:0] idx_r;

  // Sequencer registers
  logic [BIN_AW-1:0] clr_k_r;
  logic [LIM_W-1:0]  walk_k_r;
  logic              wb_valid_r;
  logic [BIN_AW-1:0] wb_addr_r;
  logic              parity_r;
  logic [LIM_W-1:0]  mark_end_r;
  logic [BIN_AW-1:0] tog_addr_r;
  logic [31:0]       event_total_r;

  // Output register
  logic              out_valid_r;
  logic [31:0]       out_bin_r;
  logic [31:0]       out_events_r;

  // Memories
  logic [31:0]       cnt_mem [MAX_BINS];
  logic              tog_mem [MAX_BINS];
  logic [31:0]       cnt_rdata_r;
  logic              tog_rdata_r;
  logic              cnt_we;
  logic [BIN_AW-1:0] cnt_waddr;
  logic [31:0]       cnt_wdata;
  logic [BIN_AW-1:0] cnt_raddr;
  logic              tog_we;
  logic [BIN_AW-1:0] tog_waddr;
  logic              tog_wdata;
  logic [BIN_AW-1:0] tog_raddr;

  // Divider link
  logic              div_start;
  logic              div_done;
  logic [DIV_W-1:0]  div_quo;
  logic [DIV_W-1:0]  div_dividend;

  // Derived values
  logic [LIM_W-1:0]  limit;
  logic [LIM_W-1:0]  fill_end;
  logic [LIM_W-1:0]  walk_end;
  logic [32:0]       pt_delta;
  logic [DIV_W:0]    q_inc;
  logic [DIV_W-1:0]  k0;
  logic              k0_in;
  logic              walk_issue;
  logic              walk_fin;
  logic              wb_par;
  logic              wb_fill;
  logic              out_free;
  logic [LIM_W-1:0]  tog_next_end;

  // Bin limit and walk extent
  always_comb begin
    limit    = (bins_in_use_r > LIM_W'(MAX_BINS)) ? LIM_W'(MAX_BINS) : bins_in_use_r;
    fill_end = (limit != '0) ? (limit - LIM_W'(1)) : '0;
    walk_end = (mark_end_r > fill_end) ? mark_end_r : fill_end;
  end

  // Point distance from the axis low edge, 33-bit signed
  always_comb begin
    pt_delta     = {pt_r[31], pt_r} - {axis_low_r[31], axis_low_r};
    div_dividend = {pt_delta[31:0], 1'b0};
    q_inc        = {1'b0, div_quo} + (DIV_W + 1)'(1);
    k0           = q_inc[DIV_W:1];
    k0_in        = (k0 < DIV_W'(limit));
  end

  // Walk pipeline status
  always_comb begin
    walk_issue   = (walk_k_r < walk_end);
    walk_fin     = !walk_issue && !wb_valid_r;
    wb_par       = parity_r ^ tog_rdata_r;
    wb_fill      = ({1'b0, wb_addr_r} < fill_end);
    out_free     = !out_valid_r || !out_stall;
    tog_next_end = {1'b0, tog_addr_r} + LIM_W'(1);
  end

  ich_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (bin_width_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_k_r == BIN_AW'(MAX_BINS - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_DECODE;
      end
      ST_DECODE: begin
        case (op_r)
          OP_ADD: begin
            if (pt_delta[32]) state_nxt = (limit != '0) ? ST_TOG_RD : ST_DONE;
            else if (bin_width_r == '0) state_nxt = ST_DONE;
            else state_nxt = ST_DIV;
          end
          OP_END:  state_nxt = ST_WALK;
          default: state_nxt = ST_DONE;
        endcase
      end
      ST_DIV: begin
        if (div_done) state_nxt = k0_in ? ST_TOG_RD : ST_DONE;
      end
      ST_TOG_RD: state_nxt = ST_TOG_WR;
      ST_TOG_WR: state_nxt = ST_DONE;
      ST_WALK: begin
        if (walk_fin) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // Outputs of the sequencer: handshake, divider start, memory ports
  always_comb begin
    in_stall  = (state_r != ST_IDLE);
    div_start = (state_r == ST_DECODE) && (op_r == OP_ADD) && !pt_delta[32] &&
                (bin_width_r != '0);
    cnt_we    = 1'b0;
    cnt_waddr = wb_addr_r;
    cnt_wdata = cnt_rdata_r + 32'd1;
    cnt_raddr = idx_r;
    tog_we    = 1'b0;
    tog_waddr = wb_addr_r;
    tog_wdata = 1'b0;
    tog_raddr = tog_addr_r;
    unique case (state_r)
      ST_CLEAR: begin
        cnt_we    = 1'b1;
        cnt_waddr = clr_k_r;
        cnt_wdata = '0;
        tog_we    = 1'b1;
        tog_waddr = clr_k_r;
      end
      ST_TOG_WR: begin
        tog_we    = 1'b1;
        tog_waddr = tog_addr_r;
        tog_wdata = !tog_rdata_r;
      end
      ST_WALK: begin
        cnt_raddr = walk_k_r[BIN_AW-1:0];
        tog_raddr = walk_k_r[BIN_AW-1:0];
        cnt_we    = wb_valid_r && wb_fill && wb_par && (cnt_rdata_r != '1);
        tog_we    = wb_valid_r;
      end
      default: ;
    endcase
  end

  // Count memory
  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
    cnt_rdata_r <= cnt_mem[cnt_raddr];
  end

  // Toggle memory
  always_ff @(posedge clk) begin
    if (tog_we) tog_mem[tog_waddr] <= tog_wdata;
    tog_rdata_r <= tog_mem[tog_raddr];
  end

  // State and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLEAR;
      axis_low_r    <= AXIS_LOW_RST;
      bin_width_r   <= BIN_WIDTH_RST;
      bins_in_use_r <= BINS_IN_USE_RST;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_AXIS_LOW:    axis_low_r    <= cfg_wdata;
          CFG_BIN_WIDTH:   bin_width_r   <= cfg_wdata;
          CFG_BINS_IN_USE: bins_in_use_r <= cfg_wdata[LIM_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Item capture on an input transfer
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      op_r  <= in_operation;
      pt_r  <= in_point_value;
      idx_r <= in_read_index;
    end
  end

  // Toggle address from a negative distance or the divider quotient
  always_ff @(posedge clk) begin
    if (state_r == ST_DECODE) tog_addr_r <= '0;
    else if (state_r == ST_DIV && div_done) tog_addr_r <= k0[BIN_AW-1:0];
  end

  // Clear pass, walk sequencing, marks extent, event total
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_k_r       <= '0;
      walk_k_r      <= '0;
      wb_valid_r    <= 1'b0;
      parity_r      <= 1'b0;
      mark_end_r    <= '0;
      event_total_r <= '0;
    end else begin
      if (state_r == ST_CLEAR) clr_k_r <= clr_k_r + BIN_AW'(1);
      if (state_r == ST_TOG_WR && tog_next_end > mark_end_r) mark_end_r <= tog_next_end;
      if (state_r == ST_DECODE) begin
        walk_k_r   <= '0;
        wb_valid_r <= 1'b0;
        parity_r   <= 1'b0;
      end else if (state_r == ST_WALK) begin
        wb_valid_r <= walk_issue;
        if (walk_issue) walk_k_r <= walk_k_r + LIM_W'(1);
        if (wb_valid_r) parity_r <= wb_par;
        if (walk_fin) begin
          mark_end_r <= '0;
          if (event_total_r != '1) event_total_r <= event_total_r + 32'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_WALK) wb_addr_r <= walk_k_r[BIN_AW-1:0];
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && out_free) begin
      out_bin_r    <= (op_r == OP_READ) ? cnt_rdata_r : '0;
      out_events_r <= event_total_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_bin_value   = out_bin_r;
  assign out_events_seen = out_events_r;

endmodule
`default_nettype wire

FILE: rtl/core/ich_div.sv
// Iterative restoring divider, one quotient bit per cycle.
`default_nettype none
module ich_div (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [ich_pkg::DIV_W-1:0]  dividend,
  input  wire logic [31:0]                divisor,
  output logic                            done,
  output logic      [ich_pkg::DIV_W-1:0]  quotient
);
  import ich_pkg::*;

  logic                busy_r;
  logic                done_r;
  logic [DIV_CW-1:0]   cnt_r;
  logic [DIV_W-1:0]    quo_r;
  logic [31:0]         rem_r;
  logic [31:0]         dsr_r;
  logic [32:0]         trial;
  logic                fits;
  logic [32:0]         diff;

  // Trial subtract of the shifted remainder
  always_comb begin
    trial = {rem_r, quo_r[DIV_W-1]};
    fits  = (trial >= {1'b0, dsr_r});
    diff  = trial - {1'b0, dsr_r};
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= DIV_CW'(DIV_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - DIV_CW'(1);
      if (cnt_r == DIV_CW'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  // Datapath: quotient bits shift in as dividend bits shift out
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIV_W-2:0], fits};
      rem_r <= fits ? diff[31:0] : trial[31:0];
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire
